### rtl/nmac_pkg.sv
// Shared types, constants and the sigmoid table for the neuron MAC block.
// No dependencies; every other design and bench file uses this package.
package nmac_pkg;

    localparam int DATA_WIDTH      = 16;
    localparam int FRAC_BITS       = 12;
    localparam int ONE_Q           = 1 << FRAC_BITS;
    localparam int PROD_WIDTH      = 2 * DATA_WIDTH;
    localparam int KEEP_WIDTH      = 13;
    localparam int ACT_MODE_WIDTH  = 2;
    localparam int CFG_IDX_WIDTH   = 2;
    localparam int CFG_DATA_WIDTH  = 13;
    localparam int ROM_DEPTH       = 256;
    localparam int ROM_IDX_WIDTH   = $clog2(ROM_DEPTH);
    localparam int ROM_WIDTH       = 13;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
    localparam int EXP_BITS        = 30;
    localparam int EXP_TERMS       = 200;
    localparam int X_CLAMP         = 12 * ONE_Q;

    typedef enum logic [ACT_MODE_WIDTH-1:0] {
        ACT_RELU     = 2'd0,
        ACT_SIGMOID  = 2'd1,
        ACT_TANH     = 2'd2,
        ACT_IDENTITY = 2'd3
    } t_act_mode;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_ACT_MODE  = 2'd0,
        CFG_DROP_EN   = 2'd1,
        CFG_KEEP_RATE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_act_mode               mode;
        logic                    drop_en;
        logic [KEEP_WIDTH-1:0]   keep;
    } t_cfg;

    typedef struct packed {
        logic                           bias;
        logic signed [PROD_WIDTH-1:0]   addend;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef logic [ROM_DEPTH-1:0][ROM_WIDTH-1:0] t_sig_rom;

    // Restoring division, evaluated only while building the table
    function automatic logic [63:0] udiv64(logic [63:0] dividend, logic [63:0] divisor);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], dividend[b]};
            if (rem >= {1'b0, divisor}) begin
                rem    = rem - {1'b0, divisor};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Rounded sigmoid at each segment midpoint, exp by truncated Taylor series
    function automatic t_sig_rom build_sig_rom();
        t_sig_rom    rom;
        logic [63:0] off;
        logic [63:0] mag;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] s;
        logic [63:0] d;
        logic [63:0] num;
        logic [63:0] q;
        longint      zm;
        int          n;
        rom = '0;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            off = (64'(2 * i + 1) << DATA_WIDTH) >> (ROM_IDX_WIDTH + 1);
            zm  = longint'(off) - (longint'(1) << (DATA_WIDTH - 1));
            mag = (zm < 0) ? 64'(-zm) : 64'(zm);
            if (mag > 64'(X_CLAMP)) begin
                mag = 64'(X_CLAMP);
            end
            term = 64'd1 << EXP_BITS;
            sum  = term;
            n    = 1;
            while (term != 64'd0 && n < EXP_TERMS) begin
                term = udiv64(term * mag, 64'(ONE_Q) * 64'(n));
                sum  = sum + term;
                n    = n + 1;
            end
            s   = 64'd1 << EXP_BITS;
            d   = s + sum;
            num = (zm >= 0) ? sum : s;
            q   = udiv64((num << (FRAC_BITS + 1)) + d, 64'd2 * d);
            rom[i] = q[ROM_WIDTH-1:0];
        end
        return rom;
    endfunction

    localparam t_sig_rom SIG_ROM = build_sig_rom();

endpackage

### rtl/nmac_in_if.sv
// Input channel: valid/ready handshake carrying one term or bias request.
// Depends on nmac_pkg for field widths.
interface nmac_in_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      kind;
    logic signed [nmac_pkg::DATA_WIDTH-1:0]    activation;
    logic signed [nmac_pkg::DATA_WIDTH-1:0]    weight;

    modport source (output valid, output kind, output activation, output weight,
                    input ready);
    modport sink   (input valid, input kind, input activation, input weight,
                    output ready);
endinterface

### rtl/nmac_out_if.sv
// Output channel: valid/ready handshake carrying one activated neuron result.
// Depends on nmac_pkg for field widths.
interface nmac_out_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [nmac_pkg::DATA_WIDTH-1:0]    value;
    logic                                      saturated;

    modport source (output valid, output value, output saturated, input ready);
    modport sink   (input valid, input value, input saturated, output ready);
endinterface

### rtl/nmac_front.sv
// Front end: accepts requests, forms the product or the scaled bias, pushes to the queue.
// Depends on nmac_pkg and nmac_in_if.
module nmac_front (
    nmac_in_if.sink            i_in,
    input  nmac_pkg::t_q_stat  i_q_stat,
    output logic               o_push,
    output nmac_pkg::t_entry   o_entry
);
    import nmac_pkg::*;

    logic signed [PROD_WIDTH-1:0] n_prod;
    logic signed [PROD_WIDTH-1:0] n_bias;

    assign i_in.ready = !i_q_stat.full;
    assign o_push     = i_in.valid && !i_q_stat.full;

    assign n_prod = i_in.activation * i_in.weight;
    assign n_bias = {{(PROD_WIDTH - DATA_WIDTH - FRAC_BITS){i_in.weight[DATA_WIDTH-1]}},
                     i_in.weight, {FRAC_BITS{1'b0}}};

    assign o_entry.bias   = i_in.kind;
    assign o_entry.addend = i_in.kind ? n_bias : n_prod;

endmodule

### rtl/nmac_fifo.sv
// Short request queue between front and back end.
// Depends on nmac_pkg.
module nmac_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  nmac_pkg::t_entry   i_entry,
    input  logic               i_pop,
    output nmac_pkg::t_entry   o_entry,
    output nmac_pkg::t_q_stat  o_stat
);
    import nmac_pkg::*;

    t_entry                     r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_WIDTH-1:0] r_wptr;
    logic [QUEUE_PTR_WIDTH-1:0] r_rptr;
    logic [QUEUE_PTR_WIDTH:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    assign o_entry      = r_mem[r_rptr];
    assign o_stat.full  = (r_count == (QUEUE_PTR_WIDTH + 1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

### rtl/nmac_back.sv
// Back end: saturating accumulator, bias close-out, activation and dropout pipeline.
// Depends on nmac_pkg and nmac_out_if.
module nmac_back #(
    parameter int ACC_WIDTH = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nmac_pkg::t_cfg     i_cfg,
    input  nmac_pkg::t_entry   i_entry,
    input  nmac_pkg::t_q_stat  i_q_stat,
    output logic               o_pop,
    nmac_out_if.source         o_res
);
    import nmac_pkg::*;

    localparam int ZHI = FRAC_BITS + DATA_WIDTH - 1;
    localparam int PW  = DATA_WIDTH + KEEP_WIDTH + 1;
    localparam logic signed [ACC_WIDTH-1:0]  ACC_MAX = {1'b0, {(ACC_WIDTH - 1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0]  ACC_MIN = {1'b1, {(ACC_WIDTH - 1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] D_MAX   = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] D_MIN   = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

    logic signed [ACC_WIDTH-1:0]  r_acc;
    logic                         r_sat_seen;

    logic                         r_v1, r_v2, r_v3, r_v4, r_ov;
    logic signed [ACC_WIDTH-1:0]  r_acc1;
    logic                         r_s1, r_s2, r_s3, r_s4;
    logic signed [DATA_WIDTH-1:0] r_z2, r_y3, r_y4;
    logic signed [PW-1:0]         r_p4;
    logic signed [DATA_WIDTH-1:0] r_oval;
    logic                         r_osat;

    logic                         ld1, ld2, ld3, ld4, ld_o;
    logic                         free1, free2, free3, free4;

    logic signed [ACC_WIDTH:0]    n_sum;
    logic                         n_ovf;
    logic signed [ACC_WIDTH-1:0]  n_acc_sat;

    logic                         n_fit2;
    logic signed [DATA_WIDTH-1:0] n_z2;

    logic                         n_fit_dbl;
    logic signed [DATA_WIDTH-1:0] n_zdbl;
    logic [ROM_IDX_WIDTH-1:0]     n_idx;
    logic [ROM_WIDTH-1:0]         n_rom;
    logic signed [DATA_WIDTH-1:0] n_y3;

    logic signed [KEEP_WIDTH:0]   n_keep;
    logic signed [PW-1:0]         n_p4;

    logic                         n_fit_o;
    logic signed [DATA_WIDTH-1:0] n_drop;
    logic signed [DATA_WIDTH-1:0] n_oval;
    logic                         n_osat;

    // Pipeline advance chain
    assign ld_o  = r_v4 && (!r_ov || o_res.ready);
    assign free4 = !r_v4 || ld_o;
    assign ld4   = r_v3 && free4;
    assign free3 = !r_v3 || ld4;
    assign ld3   = r_v2 && free3;
    assign free2 = !r_v2 || ld3;
    assign ld2   = r_v1 && free2;
    assign free1 = !r_v1 || ld2;
    assign o_pop = !i_q_stat.empty && (!i_entry.bias || free1);
    assign ld1   = o_pop && i_entry.bias;

    // Saturating accumulate
    assign n_sum = {r_acc[ACC_WIDTH-1], r_acc}
                 + {{(ACC_WIDTH + 1 - PROD_WIDTH){i_entry.addend[PROD_WIDTH-1]}},
                    i_entry.addend};
    assign n_ovf     = n_sum[ACC_WIDTH] ^ n_sum[ACC_WIDTH-1];
    assign n_acc_sat = n_ovf ? (n_sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX)
                             : n_sum[ACC_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_sat_seen <= 1'b0;
        end else if (o_pop) begin
            if (i_entry.bias) begin
                r_acc      <= '0;
                r_sat_seen <= 1'b0;
            end else begin
                r_acc      <= n_acc_sat;
                r_sat_seen <= r_sat_seen | n_ovf;
            end
        end
    end

    // Floor to Q4.12 and clamp
    assign n_fit2 = (&r_acc1[ACC_WIDTH-1:ZHI]) || !(|r_acc1[ACC_WIDTH-1:ZHI]);
    assign n_z2   = n_fit2 ? r_acc1[ZHI:FRAC_BITS]
                           : (r_acc1[ACC_WIDTH-1] ? D_MIN : D_MAX);

    // Activation
    assign n_fit_dbl = (r_z2[DATA_WIDTH-1] == r_z2[DATA_WIDTH-2]);
    assign n_zdbl    = n_fit_dbl ? {r_z2[DATA_WIDTH-2:0], 1'b0}
                                 : (r_z2[DATA_WIDTH-1] ? D_MIN : D_MAX);

    always_comb begin
        if (i_cfg.mode == ACT_TANH) begin
            n_idx = {~n_zdbl[DATA_WIDTH-1], n_zdbl[DATA_WIDTH-2 -: ROM_IDX_WIDTH-1]};
        end else begin
            n_idx = {~r_z2[DATA_WIDTH-1], r_z2[DATA_WIDTH-2 -: ROM_IDX_WIDTH-1]};
        end
        n_rom = SIG_ROM[n_idx];
        case (i_cfg.mode)
            ACT_RELU:     n_y3 = r_z2[DATA_WIDTH-1] ? '0 : r_z2;
            ACT_SIGMOID:  n_y3 = DATA_WIDTH'(n_rom);
            ACT_TANH:     n_y3 = DATA_WIDTH'({n_rom, 1'b0}) - DATA_WIDTH'(ONE_Q);
            ACT_IDENTITY: n_y3 = r_z2;
            default:      n_y3 = r_z2;
        endcase
    end

    // Dropout scaling
    assign n_keep = {1'b0, i_cfg.keep};
    assign n_p4   = r_y3 * n_keep;

    assign n_fit_o = (&r_p4[PW-1:ZHI]) || !(|r_p4[PW-1:ZHI]);
    assign n_drop  = n_fit_o ? r_p4[ZHI:FRAC_BITS] : (r_p4[PW-1] ? D_MIN : D_MAX);
    assign n_oval  = i_cfg.drop_en ? n_drop : r_y4;
    assign n_osat  = r_s4 | (i_cfg.drop_en & ~n_fit_o);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_v1 <= ld1  | (r_v1 & ~ld2);
            r_v2 <= ld2  | (r_v2 & ~ld3);
            r_v3 <= ld3  | (r_v3 & ~ld4);
            r_v4 <= ld4  | (r_v4 & ~ld_o);
            r_ov <= ld_o | (r_ov & ~o_res.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_acc1 <= n_acc_sat;
            r_s1   <= r_sat_seen | n_ovf;
        end
        if (ld2) begin
            r_z2 <= n_z2;
            r_s2 <= r_s1 | ~n_fit2;
        end
        if (ld3) begin
            r_y3 <= n_y3;
            r_s3 <= r_s2;
        end
        if (ld4) begin
            r_p4 <= n_p4;
            r_y4 <= r_y3;
            r_s4 <= r_s3;
        end
        if (ld_o) begin
            r_oval <= n_oval;
            r_osat <= n_osat;
        end
    end

    assign o_res.valid     = r_ov;
    assign o_res.value     = r_oval;
    assign o_res.saturated = r_osat;

endmodule

### rtl/neuron_mac_with_activation_top.sv
// Channel   Direction  Handshake      Payload
// i_in      in         valid/ready    kind, activation, weight
// o_res     out        valid/ready    value, saturated
// i_cfg_*   in         write enable   register index, write data
//
// One request per cycle sustained while the queue has room; the back end retires one
// queue entry per cycle unless a bias entry waits on a full close-out pipeline. Term
// requests give no result; a bias result leaves the five-stage pipeline behind the adder.
// Reset clears the queue, accumulator, configuration and pipeline valid bits.
// An o_res stall fills the close-out pipeline, then the four-entry queue, then drops
// i_in.ready.
// Top level of the neuron MAC block; depends on nmac_pkg, the channel interfaces,
// nmac_front, nmac_fifo and nmac_back.
module neuron_mac_with_activation_top #(
    parameter int ACC_WIDTH = 48
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    nmac_in_if.sink                              i_in,
    nmac_out_if.source                           o_res,
    input  logic                                 i_cfg_we,
    input  logic [nmac_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_idx,
    input  logic [nmac_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data
);
    import nmac_pkg::*;

    t_cfg    r_cfg;
    t_entry  push_entry;
    t_entry  pop_entry;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode    <= ACT_RELU;
            r_cfg.drop_en <= 1'b0;
            r_cfg.keep    <= KEEP_WIDTH'(ONE_Q);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ACT_MODE:  r_cfg.mode    <= t_act_mode'(i_cfg_data[ACT_MODE_WIDTH-1:0]);
                CFG_DROP_EN:   r_cfg.drop_en <= i_cfg_data[0];
                CFG_KEEP_RATE: r_cfg.keep    <= i_cfg_data[KEEP_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    nmac_front u_front (
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    nmac_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (pop_entry),
        .o_stat   (q_stat)
    );

    nmac_back #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_entry  (pop_entry),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_res    (o_res)
    );

endmodule

### rtl/nmac_checker.sv
// Port-level checks for the neuron MAC block, bound to the top level.
// Depends on nmac_pkg.
module nmac_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  i_in_ready,
    input logic                                  i_in_kind,
    input logic                                  i_out_valid,
    input logic                                  i_out_ready,
    input logic [nmac_pkg::DATA_WIDTH-1:0]       i_out_value,
    input logic                                  i_out_sat,
    input logic                                  i_cfg_we,
    input logic [nmac_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_idx,
    input logic [nmac_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data
);
    import nmac_pkg::*;

    logic [7:0] r_pending;
    t_act_mode  r_mode;
    logic       r_drop;
    logic       in_bias;
    logic       out_take;

    assign in_bias  = i_in_valid && i_in_ready && i_in_kind;
    assign out_take = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_mode    <= ACT_RELU;
            r_drop    <= 1'b0;
        end else begin
            r_pending <= r_pending + 8'(in_bias) - 8'(out_take);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ACT_MODE: r_mode <= t_act_mode'(i_cfg_data[ACT_MODE_WIDTH-1:0]);
                    CFG_DROP_EN:  r_drop <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    a_result_has_bias: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != 8'd0)
        else $error("result shown with no bias request outstanding");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value)
                                        && $stable(i_out_sat))
        else $error("stalled result changed");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid straight after reset");

    a_relu_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_mode == ACT_RELU |-> !i_out_value[DATA_WIDTH-1])
        else $error("negative relu result");

    a_sigmoid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_mode == ACT_SIGMOID && !r_drop |->
            !i_out_value[DATA_WIDTH-1] && i_out_value <= DATA_WIDTH'(ONE_Q))
        else $error("sigmoid result out of range");

endmodule

bind neuron_mac_with_activation_top nmac_checker u_nmac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_kind   (i_in.kind),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_value (o_res.value),
    .i_out_sat   (o_res.saturated),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_idx   (i_cfg_idx),
    .i_cfg_data  (i_cfg_data)
);

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for neuron_mac_with_activation_top: drives term and bias requests,
// predicts each neuron output and compares it. Needs nmac_pkg and the channel interfaces.
module tb;
    import nmac_pkg::*;

    localparam int              ACC_W          = 48;
    localparam logic            KIND_TERM      = 1'b0;
    localparam logic            KIND_BIAS      = 1'b1;
    localparam logic [1:0]      CFG_UNUSED     = 2'd3;
    localparam logic [12:0]     KEEP_MAX       = 13'h1FFF;
    localparam int              SETTLE_CYCLES  = 20;
    localparam int              WATCHDOG_LIMIT = 2000;
    localparam int              LONG_HOLD      = 80;

    typedef struct {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         saturated;
    } t_neuron_out;

    class neuron_checker;
        localparam longint ACC_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
        localparam longint ACC_MIN = -ACC_MAX - 1;
        localparam longint D_MAX   = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
        localparam longint D_MIN   = -D_MAX - 1;

        longint          acc_sum;
        bit              acc_clipped;
        t_act_mode       mode;
        bit              drop_en;
        logic [12:0]     keep;
        logic [12:0]     sig_lut [ROM_DEPTH];
        t_neuron_out     pending_outputs [$];
        int              errors;
        int              outputs_checked;

        function new();
            longint unsigned off, mag, term, sum, d, num, one;
            longint          zm;
            one = longint'(1) << EXP_BITS;
            for (int i = 0; i < ROM_DEPTH; i++) begin
                off = (longint'(2 * i + 1) << DATA_WIDTH) / (2 * ROM_DEPTH);
                zm  = longint'(off) - (longint'(1) <<< (DATA_WIDTH - 1));
                mag = (zm < 0) ? -zm : zm;
                if (mag > X_CLAMP) mag = X_CLAMP;
                term = one;
                sum  = one;
                for (int n = 1; n < EXP_TERMS; n++) begin
                    term = (term * mag) / (longint'(ONE_Q) * n);
                    if (term == 0) break;
                    sum += term;
                end
                d   = one + sum;
                num = (zm >= 0) ? sum : one;
                sig_lut[i] = 13'(((num << (FRAC_BITS + 1)) + d) / (2 * d));
            end
            acc_sum     = 0;
            acc_clipped = 0;
            mode        = ACT_RELU;
            drop_en     = 0;
            keep        = 13'(ONE_Q);
            errors      = 0;
            outputs_checked = 0;
        endfunction

        function void set_config(t_act_mode m, bit en, logic [12:0] k);
            mode    = m;
            drop_en = en;
            keep    = k;
        endfunction

        function longint acc_sat_add(longint a, longint b, inout bit flag);
            if (b > 0 && a > ACC_MAX - b) begin
                flag = 1;
                return ACC_MAX;
            end
            if (b < 0 && a < ACC_MIN - b) begin
                flag = 1;
                return ACC_MIN;
            end
            return a + b;
        endfunction

        function longint clamp_data(longint v, inout bit flag);
            if (v > D_MAX) begin
                flag = 1;
                return D_MAX;
            end
            if (v < D_MIN) begin
                flag = 1;
                return D_MIN;
            end
            return v;
        endfunction

        function longint sigmoid_lookup(longint z);
            return longint'(sig_lut[int'((z - D_MIN) >>> (DATA_WIDTH - ROM_IDX_WIDTH))]);
        endfunction

        function void note_request(logic kind, logic signed [DATA_WIDTH-1:0] a,
                                   logic signed [DATA_WIDTH-1:0] w);
            bit          sat;
            bit          dummy;
            longint      t, z, y;
            t_neuron_out res;
            if (kind == KIND_TERM) begin
                acc_sum = acc_sat_add(acc_sum, longint'(a) * longint'(w), acc_clipped);
                return;
            end
            sat   = acc_clipped;
            dummy = 0;
            t = acc_sat_add(acc_sum, longint'(w) * ONE_Q, sat);
            z = clamp_data(t >>> FRAC_BITS, sat);
            case (mode)
                ACT_RELU:    y = (z > 0) ? z : 0;
                ACT_SIGMOID: y = sigmoid_lookup(z);
                ACT_TANH:    y = 2 * sigmoid_lookup(clamp_data(2 * z, dummy)) - ONE_Q;
                default:     y = z;
            endcase
            if (drop_en) y = clamp_data((y * longint'(keep)) >>> FRAC_BITS, sat);
            res.value     = DATA_WIDTH'(y);
            res.saturated = sat;
            pending_outputs.push_back(res);
            acc_sum     = 0;
            acc_clipped = 0;
        endfunction

        function void check_result(logic signed [DATA_WIDTH-1:0] value, logic saturated);
            t_neuron_out exp_res;
            if (pending_outputs.size() == 0) begin
                $error("result with nothing outstanding: value %0d saturated %0b",
                       value, saturated);
                errors++;
                return;
            end
            exp_res = pending_outputs.pop_front();
            outputs_checked++;
            if (value !== exp_res.value) begin
                $error("value: expected %0d, got %0d", exp_res.value, value);
                errors++;
            end
            if (saturated !== exp_res.saturated) begin
                $error("saturated: expected %0b, got %0b", exp_res.saturated, saturated);
                errors++;
            end
        endfunction

        function int pending();
            return pending_outputs.size();
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CFG_IDX_WIDTH-1:0]   i_cfg_idx;
    logic [CFG_DATA_WIDTH-1:0]  i_cfg_data;

    nmac_in_if  in_ch ();
    nmac_out_if res_ch ();

    neuron_mac_with_activation_top #(
        .ACC_WIDTH (ACC_W)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    neuron_checker chk;
    bit            calm;
    bit            squeeze;
    bit            squeeze_done;
    int            hold_left;
    int            quiet_cycles;
    int            requests_sent;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            chk.check_result(res_ch.value, res_ch.saturated);
        end
        if (squeeze && !squeeze_done) begin
            hold_left    = LONG_HOLD;
            squeeze_done = 1;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= calm || ($urandom_range(99) >= 11);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no request or result moved for %0d cycles", quiet_cycles);
            $display("[neuron_mac_with_activation_top] ERROR");
            $finish;
        end
    end

    function automatic logic signed [DATA_WIDTH-1:0] pick_field();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2, 3, 4: return DATA_WIDTH'($urandom_range(4095)) - 16'sd2048;
            default: return DATA_WIDTH'($urandom);
        endcase
    endfunction

    task automatic send_req(logic kind, logic signed [DATA_WIDTH-1:0] a,
                            logic signed [DATA_WIDTH-1:0] w);
        while (!calm && $urandom_range(99) < 11) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= kind;
        in_ch.activation <= a;
        in_ch.weight     <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        chk.note_request(kind, a, w);
        requests_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (chk.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(t_act_mode mode, bit en, logic [12:0] keep, bit poke_unused);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_ACT_MODE;
        i_cfg_data <= CFG_DATA_WIDTH'(mode);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DROP_EN;
        i_cfg_data <= CFG_DATA_WIDTH'(en);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_KEEP_RATE;
        i_cfg_data <= keep;
        @(posedge i_clk);
        if (poke_unused) begin
            i_cfg_idx  <= CFG_UNUSED;
            i_cfg_data <= CFG_DATA_WIDTH'($urandom);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        chk.set_config(mode, en, keep);
    endtask

    initial begin
        int          sent;
        int          len;
        logic [12:0] k;
        chk              = new();
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        in_ch.valid      = 1'b0;
        in_ch.kind       = KIND_TERM;
        in_ch.activation = '0;
        in_ch.weight     = '0;
        res_ch.ready     = 1'b0;
        calm             = 0;
        squeeze          = 0;
        squeeze_done     = 0;
        hold_left        = 0;
        quiet_cycles     = 0;
        requests_sent    = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        configure(ACT_RELU, 0, 13'(ONE_Q), 1);
        send_req(KIND_BIAS, 16'sd0, 16'sd0);
        send_req(KIND_TERM, 16'sh7FFF, 16'sh7FFF);
        send_req(KIND_BIAS, 16'sd0, 16'sh8000);
        send_req(KIND_TERM, 16'sh8000, 16'sh7FFF);
        send_req(KIND_BIAS, 16'sd0, 16'sd0);
        drain();

        configure(ACT_IDENTITY, 0, 13'(ONE_Q), 0);
        send_req(KIND_TERM, -16'sd1, 16'sd1);
        send_req(KIND_BIAS, 16'sd0, 16'sd0);
        send_req(KIND_TERM, 16'sh8000, 16'sh8000);
        send_req(KIND_TERM, 16'sh8000, 16'sh8000);
        send_req(KIND_BIAS, 16'sd0, 16'sh7FFF);
        send_req(KIND_BIAS, -16'sd1, 16'sh7FFF);
        send_req(KIND_BIAS, 16'sd0, 16'sh8000);
        drain();

        configure(ACT_SIGMOID, 0, 13'(ONE_Q), 0);
        send_req(KIND_BIAS, 16'sd0, 16'sh8000);
        send_req(KIND_BIAS, 16'sd0, 16'sd0);
        send_req(KIND_BIAS, 16'sd0, 16'sh7FFF);
        send_req(KIND_TERM, 16'sd4096, 16'sd4096);
        send_req(KIND_BIAS, 16'sd0, -16'sd1);
        drain();

        configure(ACT_TANH, 0, 13'(ONE_Q), 0);
        send_req(KIND_BIAS, 16'sd0, 16'sd20000);
        send_req(KIND_BIAS, 16'sd0, -16'sd20000);
        send_req(KIND_TERM, 16'sd6000, 16'sd4096);
        send_req(KIND_BIAS, 16'sd0, 16'sd0);
        drain();

        configure(ACT_IDENTITY, 1, KEEP_MAX, 0);
        send_req(KIND_BIAS, 16'sd0, 16'sh7FFF);
        send_req(KIND_BIAS, 16'sd0, 16'sh8000);
        drain();
        configure(ACT_IDENTITY, 1, 13'd0, 0);
        send_req(KIND_BIAS, 16'sd0, 16'sd1234);
        drain();

        for (int p = 0; p < 10; p++) begin
            case (p)
                0:       k = 13'd0;
                1:       k = KEEP_MAX;
                2:       k = 13'(ONE_Q);
                default: k = 13'($urandom_range(KEEP_MAX));
            endcase
            configure(t_act_mode'(p % 4), (p < 2) ? 1'b1 : 1'($urandom), k, 0);
            calm <= (p == 2);
            if (p == 3) squeeze <= 1;
            sent = 0;
            while (sent < 50) begin
                len = $urandom_range(7);
                repeat (len) send_req(KIND_TERM, pick_field(), pick_field());
                send_req(KIND_BIAS, DATA_WIDTH'($urandom), pick_field());
                sent += len + 1;
            end
            drain();
        end

        $display("Sent %0d requests and checked %0d neuron outputs over all activations,",
                 requests_sent, chk.outputs_checked);
        $display("dropout scaling, output saturation and a long result stall.");
        if (chk.errors == 0 && chk.pending() == 0) begin
            $display("[neuron_mac_with_activation_top] OK");
        end else begin
            $display("[neuron_mac_with_activation_top] ERROR");
        end
        $finish;
    end

endmodule

### sim.f
rtl/nmac_pkg.sv
rtl/nmac_in_if.sv
rtl/nmac_out_if.sv
rtl/nmac_front.sv
rtl/nmac_fifo.sv
rtl/nmac_back.sv
rtl/neuron_mac_with_activation_top.sv
rtl/nmac_checker.sv
tb/tb.sv
